### rtl/bbrf_pkg.sv
// Box blur row filter: shared constants.
// Used by the top level, the scaling unit and the port checker.
package bbrf_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int SAMPLE_BITS = 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int RADIUS_BITS   = 4;
  localparam int INV_BITS      = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS     = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_WINDOW = 1'b1;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;
  localparam logic [INV_BITS-1:0]    INV_RESET    = 16'd21845;

  // Half an LSB of the Q0.16 product, for round half up
  localparam int ROUND_HALF = 1 << (INV_BITS - 1);

endpackage

### rtl/bbrf_scale.sv
// Box blur row filter: window sum times Q0.16 reciprocal, rounded and saturated.
// Product registered on load_i; rounding and clamp follow the register.
// Depends on bbrf_pkg.
module bbrf_scale #(
  parameter int SUM_BITS    = 13,
  parameter int SAMPLE_BITS = bbrf_pkg::SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [SUM_BITS-1:0]           sum_i,
  input  logic [bbrf_pkg::INV_BITS-1:0] inv_i,
  output logic [SAMPLE_BITS-1:0]        pix_o
);

  localparam int PW = SUM_BITS + bbrf_pkg::INV_BITS;

  logic [PW-1:0]       prod_q;
  logic [PW:0]         rnd;
  logic [SUM_BITS:0]   scaled;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PW'(sum_i) * PW'(inv_i);
    end
  end

  assign rnd    = {1'b0, prod_q} + (PW + 1)'(bbrf_pkg::ROUND_HALF);
  assign scaled = rnd[PW:bbrf_pkg::INV_BITS];

  // anything above the sample range clamps to full scale
  assign pix_o = (|scaled[SUM_BITS:SAMPLE_BITS]) ? '1 : scaled[SAMPLE_BITS-1:0];

endmodule

### rtl/box_blur_row_filter.sv
// Box blur row filter: horizontal box mean with edge replication, top level.
// Holds the sample memory, the running sum and the item sequencer.
// Depends on bbrf_pkg and bbrf_scale.
//
// Use: samples of a row enter on the s_axis channel, tlast on the last sample of the row.
// Results leave on m_axis, the mean of 2r+1 samples around one row position, with the
// first and last samples of the row repeated past its ends; tlast marks the final
// result of a row. Results lag the input by r samples, and the row-end sample flushes
// the r (or fewer, for a short row) pending results.
// radius and inv_window are to be written through the cfg port while the block is idle;
// the block itself does not enforce this. Samples sit in a 2^AW-entry circular memory;
// each result updates the running sum by one memory read (sample leaving the window).
// An item passes through ST_SUM, ST_MUL and ST_PUT, and a row-end item repeats
// ST_FL_RD, ST_FL_ADD, ST_MUL and ST_PUT for each further flushed position; no new item
// is taken until the sequencer is back in ST_IDLE. A radius that differs from the one
// used earlier in the row makes ST_RC_RD and ST_RC_ADD rebuild the sum from memory.
// The result sits in an output register, so the next item is taken while it waits;
// a stalled receiver holds the sequencer only when a further result must be loaded.
// Reset clears the control and configuration registers (radius 1, inv_window 21845)
// and starts a new row; the memory needs no clearing.
module box_blur_row_filter #(
  parameter int MAX_RADIUS  = bbrf_pkg::MAX_RADIUS,
  parameter int SAMPLE_BITS = bbrf_pkg::SAMPLE_BITS,
  localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [bbrf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bbrf_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [TDW-1:0]                     s_axis_tdata,  // sample, zero padded
  input  logic                               s_axis_tlast,  // row_end
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [TDW-1:0]                     m_axis_tdata,  // blurred, zero padded
  output logic                               m_axis_tlast   // last_of_row
);

  localparam int AW      = $clog2(2 * MAX_RADIUS + 2);
  localparam int DEPTH   = 1 << AW;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int CW      = (RW > bbrf_pkg::RADIUS_BITS) ? RW : bbrf_pkg::RADIUS_BITS;
  localparam int SW      = SAMPLE_BITS + AW;
  localparam int EW      = AW + 1;
  localparam int POS_SAT = 2 * MAX_RADIUS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_RC_RD,
    ST_RC_ADD,
    ST_MUL,
    ST_PUT,
    ST_FL_RD,
    ST_FL_ADD
  } state_e;

  state_e                              state_q, state_d;
  logic [bbrf_pkg::RADIUS_BITS-1:0]    radius_q, radius_d;
  logic [bbrf_pkg::INV_BITS-1:0]       inv_q, inv_d;
  logic [AW-1:0]                       wa_q, wa_d;
  logic [AW-1:0]                       pos_q, pos_d;
  logic [SAMPLE_BITS-1:0]              first_q, first_d;
  logic [SAMPLE_BITS-1:0]              smp_q, smp_d;
  logic                                end_q, end_d;
  logic [AW-1:0]                       n_q, n_d;
  logic [RW-1:0]                       r_q, r_d;
  logic [RW-1:0]                       r_run_q, r_run_d;
  logic [SW-1:0]                       sum_q, sum_d;
  logic [RW-1:0]                       j_q, j_d;
  logic [AW-1:0]                       k_q, k_d;
  logic                                out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]              out_pix_q, out_pix_d;
  logic                                out_last_q, out_last_d;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_raddr;

  logic                   in_acc;
  logic                   out_free;
  logic [RW-1:0]          r_eff;
  logic [CW-1:0]          rad_ext;
  logic [EW-1:0]          n_e, r_e, two_r, j_e, k_e, two_r_eff;
  logic                   emit;
  logic                   scale_load;
  logic [SAMPLE_BITS-1:0] pix;
  logic [SAMPLE_BITS-1:0] leave;
  logic [SW-1:0]          init_sum;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign rad_ext   = CW'(radius_q);
  assign r_eff     = (rad_ext > CW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(rad_ext);
  assign two_r_eff = EW'(r_eff) << 1;

  assign n_e   = EW'(n_q);
  assign r_e   = EW'(r_q);
  assign two_r = r_e << 1;
  assign j_e   = EW'(j_q);
  assign k_e   = EW'(k_q);

  // position n - r + j is inside the row
  assign emit     = (n_e + j_e) >= r_e;
  assign init_sum = SW'(smp_q) * SW'({r_q, 1'b1});

  bbrf_scale #(
    .SUM_BITS   (SW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk_i (clk_i),
    .load_i(scale_load),
    .sum_i (sum_q),
    .inv_i (inv_q),
    .pix_o (pix)
  );

  always_comb begin
    state_d     = state_q;
    radius_d    = radius_q;
    inv_d       = inv_q;
    wa_d        = wa_q;
    pos_d       = pos_q;
    first_d     = first_q;
    smp_d       = smp_q;
    end_d       = end_q;
    n_d         = n_q;
    r_d         = r_q;
    r_run_d     = r_run_q;
    sum_d       = sum_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = wa_q;
    scale_load  = 1'b0;
    leave       = first_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbrf_pkg::REG_RADIUS:     radius_d = cfg_data_i[bbrf_pkg::RADIUS_BITS-1:0];
        bbrf_pkg::REG_INV_WINDOW: inv_d    = cfg_data_i[bbrf_pkg::INV_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // newest sample goes to wa+1; the one leaving the window is 2r+1 back
          wa_d      = wa_q + AW'(1);
          mem_we    = 1'b1;
          mem_re    = 1'b1;
          mem_raddr = wa_q - AW'(two_r_eff);
          smp_d     = s_axis_tdata[SAMPLE_BITS-1:0];
          end_d     = s_axis_tlast;
          n_d       = pos_q;
          r_d       = r_eff;
          if (pos_q == '0) begin
            first_d = s_axis_tdata[SAMPLE_BITS-1:0];
          end
          if (s_axis_tlast) begin
            pos_d = '0;
          end else if (pos_q != AW'(POS_SAT)) begin
            pos_d = pos_q + AW'(1);
          end
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        j_d     = '0;
        r_run_d = r_q;
        if (n_q == '0) begin
          sum_d   = init_sum;
          state_d = ST_MUL;
        end else if (r_q != r_run_q) begin
          sum_d   = '0;
          k_d     = '0;
          state_d = ST_RC_RD;
        end else begin
          leave   = (n_e < two_r + EW'(1)) ? first_q : rd_q;
          sum_d   = sum_q + SW'(smp_q) - SW'(leave);
          state_d = ST_MUL;
        end
      end
      ST_RC_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wa_q - k_q;
        state_d   = ST_RC_ADD;
      end
      ST_RC_ADD: begin
        leave = (k_e > n_e) ? first_q : rd_q;
        sum_d = sum_q + SW'(leave);
        if (k_e == two_r) begin
          state_d = ST_MUL;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = ST_RC_RD;
        end
      end
      ST_MUL: begin
        scale_load = 1'b1;
        state_d    = ST_PUT;
      end
      ST_PUT: begin
        if (!emit || out_free) begin
          if (emit) begin
            out_valid_d = 1'b1;
            out_pix_d   = pix;
            out_last_d  = end_q && (j_q == r_q);
          end
          state_d = (end_q && (j_q != r_q)) ? ST_FL_RD : ST_IDLE;
        end
      end
      ST_FL_RD: begin
        // sample at position n - 2r + j leaves the window
        mem_re    = 1'b1;
        mem_raddr = wa_q - AW'(two_r - j_e);
        state_d   = ST_FL_ADD;
      end
      ST_FL_ADD: begin
        leave   = ((n_e + j_e) < two_r) ? first_q : rd_q;
        sum_d   = sum_q + SW'(smp_q) - SW'(leave);
        j_d     = j_q + RW'(1);
        state_d = ST_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= bbrf_pkg::RADIUS_RESET;
      inv_q       <= bbrf_pkg::INV_RESET;
      wa_q        <= '0;
      pos_q       <= '0;
      first_q     <= '0;
      end_q       <= 1'b0;
      n_q         <= '0;
      r_q         <= '0;
      r_run_q     <= RW'(bbrf_pkg::RADIUS_RESET);
      sum_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      inv_q       <= inv_d;
      wa_q        <= wa_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      end_q       <= end_d;
      n_q         <= n_d;
      r_q         <= r_d;
      r_run_q     <= r_run_d;
      sum_q       <= sum_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q     <= smp_d;
    out_pix_q <= out_pix_d;
  end

  // sample memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wa_d] <= smp_d;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'(out_pix_q);
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/bbrf_checker.sv
// Box blur row filter: port-level checks, bound to the top level.
// Depends on bbrf_pkg for the default sample width.
module bbrf_checker #(
  parameter int SAMPLE_BITS = bbrf_pkg::SAMPLE_BITS,
  localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic           m_axis_tlast
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // one item at a time: no new transaction straight after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while previous item in progress");

  // a fresh result may not rise too soon after an input transaction
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3))
    else $error("result appeared too soon after an input transaction");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind box_blur_row_filter bbrf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bbrf_checker (.*);

### tb/bbrf_tb_checker.sv
// Box blur row filter testbench: channel checker.
// Watches the cfg port and both streams, predicts each blurred result and compares.
// Depends on bbrf_pkg.
module bbrf_tb_checker
  import bbrf_pkg::*;
#(
  parameter int TDW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_valid_i,
  input  logic                     s_ready_i,
  input  logic [TDW-1:0]           s_data_i,   // sample
  input  logic                     s_last_i,   // row_end
  input  logic                     m_valid_i,
  input  logic                     m_ready_i,
  input  logic [TDW-1:0]           m_data_i,   // blurred
  input  logic                     m_last_i,   // last_of_row
  output int                       mismatches_o,
  output int                       pending_o
);

  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int POS_LIMIT   = 2 * MAX_RADIUS + 1;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] blurred;
    logic                   last_of_row;
  } blur_out_t;

  logic [SAMPLE_BITS-1:0]         line_buf [STORE_DEPTH];  // newest first
  logic [12:0]                    win_sum;
  logic [$clog2(POS_LIMIT+1)-1:0] row_pos;
  logic [SAMPLE_BITS-1:0]         row_head;
  logic [RADIUS_BITS-1:0]         radius;
  logic [INV_BITS-1:0]            inv_window;
  blur_out_t                      means_q [$];

  // Sum of the window centred on row position p; n is the newest position.
  function automatic int span_total(input int p, input int n, input int r);
    int acc;
    int q;
    acc = 0;
    for (int d = -r; d <= r; d++) begin
      q = p + d;
      if (q < 0) acc += row_head;
      else if (q > n) acc += line_buf[0];
      else if (n - q < STORE_DEPTH) acc += line_buf[n - q];
    end
    return acc;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] to_mean(input logic [12:0] total);
    logic [47:0] prod;
    prod = (48'(total) * 48'(inv_window) + 48'(ROUND_HALF)) >> INV_BITS;
    return (prod > 48'(FULL_SCALE)) ? FULL_SCALE : prod[SAMPLE_BITS-1:0];
  endfunction

  task automatic advance_row(input logic [SAMPLE_BITS-1:0] px, input logic row_end);
    int n;
    int r;
    int p_lo;
    int p_hi;
    n = row_pos;
    r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
    for (int i = STORE_DEPTH - 1; i > 0; i--) line_buf[i] = line_buf[i-1];
    line_buf[0] = px;
    if (n == 0) row_head = px;
    // row end flushes every position still owed, clamped to the row start
    if (row_end) begin
      p_lo = (n >= r) ? n - r : 0;
      p_hi = n;
    end else begin
      p_lo = n - r;
      p_hi = n - r;
    end
    for (int p = p_lo; p <= p_hi; p++) begin
      if (p >= 0) begin
        win_sum = 13'(span_total(p, n, r));
        means_q.push_back(blur_out_t'{blurred: to_mean(win_sum),
                                      last_of_row: row_end && (p == p_hi)});
      end
    end
    if (row_end) row_pos = '0;
    else if (row_pos < POS_LIMIT) row_pos++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_out_t want;
    if (!rst_ni) begin
      radius       = RADIUS_RESET;
      inv_window   = INV_RESET;
      win_sum      = '0;
      row_pos      = '0;
      row_head     = '0;
      for (int i = 0; i < STORE_DEPTH; i++) line_buf[i] = '0;
      means_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS:     radius = cfg_data_i[RADIUS_BITS-1:0];
          REG_INV_WINDOW: inv_window = cfg_data_i[INV_BITS-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) advance_row(s_data_i[SAMPLE_BITS-1:0], s_last_i);
      if (m_valid_i && m_ready_i) begin
        if (means_q.size() == 0) begin
          $error("unexpected result: blurred %0d last_of_row %0b",
                 m_data_i[SAMPLE_BITS-1:0], m_last_i);
          mismatches_o++;
        end else begin
          want = means_q.pop_front();
          if (m_data_i[SAMPLE_BITS-1:0] !== want.blurred) begin
            $error("blurred: expected %0d, actual %0d", want.blurred,
                   m_data_i[SAMPLE_BITS-1:0]);
            mismatches_o++;
          end
          if (m_last_i !== want.last_of_row) begin
            $error("last_of_row: expected %0b, actual %0b", want.last_of_row, m_last_i);
            mismatches_o++;
          end
        end
      end
      pending_o = means_q.size();
    end
  end

endmodule

### tb/tb.sv
// Box blur row filter testbench: clock, reset, stimulus and verdict.
// Drives box_blur_row_filter and checks it through bbrf_tb_checker; uses bbrf_pkg.
module tb;
  import bbrf_pkg::*;

  localparam int TDW           = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_ITEMS   = 30;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [TDW-1:0]           s_axis_tdata;
  logic                     s_axis_tlast;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [TDW-1:0]           m_axis_tdata;
  logic                     m_axis_tlast;
  int                       fail_count;
  int                       means_owed;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  int                       cycle_count;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  box_blur_row_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bbrf_tb_checker #(.TDW(TDW)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .mismatches_o (fail_count),
    .pending_o    (means_owed)
  );

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [15:0] recip_q16(input int r);
    int w;
    int q;
    w = 2 * r + 1;
    q = (65536 + w / 2) / w;
    return (q > 65535) ? 16'hffff : 16'(q);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] any_pixel();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return SAMPLE_BITS'($urandom);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_window(input int r, input logic [INV_BITS-1:0] inv);
    write_reg(REG_RADIUS, CFG_DATA_BITS'(r));
    write_reg(REG_INV_WINDOW, CFG_DATA_BITS'(inv));
  endtask

  // One sample transaction, with random idle cycles in front of it
  task automatic push_pixel(input logic [SAMPLE_BITS-1:0] px, input logic row_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDW'(px);
    s_axis_tlast  <= row_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain the results, then let any result-free item finish inside the block
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (means_owed != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int r;
    int len;
    int k;
    int sent;
    logic [INV_BITS-1:0] inv;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 22;
    recv_stall_pct = 57;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset window (r = 1): single-sample row, then sample extremes
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    settle();
    set_window(3, recip_q16(3));
    // row shorter than the window
    push_pixel(8'd17, 1'b0);
    push_pixel(8'd200, 1'b1);
    // radius changed part-way through a row
    for (int i = 1; i <= 5; i++) push_pixel(SAMPLE_BITS'(10 * i), 1'b0);
    settle();
    write_reg(REG_RADIUS, CFG_DATA_BITS'(1));
    push_pixel(8'd60, 1'b0);
    push_pixel(8'd70, 1'b1);
    settle();
    // zero reciprocal
    set_window(2, '0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b1);
    settle();
    // reciprocal far too large, mean saturates
    set_window(15, 16'hffff);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd254, 1'b1);
    settle();
    set_window(0, 16'hffff);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd254, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph / 3)
        0: begin
          send_idle_pct  = 22;
          recv_stall_pct = 57;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0, 6:    r = 0;
        1, 5:    r = MAX_RADIUS;
        default: r = $urandom_range(MAX_RADIUS - 1, 1);
      endcase
      if (ph == 4) inv = INV_BITS'($urandom);
      else if (ph == 7) inv = 16'hffff;
      else inv = recip_q16(r);
      // a row left open by the previous phase continues under the new window
      set_window(r, inv);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        k = $urandom_range(99);
        if (k < 15) len = $urandom_range(3, 1);
        else if (k < 30) len = $urandom_range(2 * MAX_RADIUS + 15, 2 * MAX_RADIUS + 2);
        else len = $urandom_range(2 * r + 3, 1);
        for (int i = 0; i < len; i++) push_pixel(any_pixel(), i == len - 1);
        sent += len;
      end
      if (ph % 3 != 2) begin
        repeat ($urandom_range(6, 1)) push_pixel(any_pixel(), 1'b0);
      end
    end
    settle();

    if (fail_count == 0 && means_owed == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
